/* sv/bto_pkg.sv */
// Shared constants, types and widths for the binarize and tile occupancy block.
package bto_pkg;

    // Frame geometry.
    localparam int unsigned TILE_SIZE    = 50;
    localparam int unsigned TILES_ACROSS = 6;
    localparam int unsigned TILES_DOWN   = 6;

    // Counter widths derived from the geometry.
    localparam int unsigned TS_W = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
    localparam int unsigned TC_W = (TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1;
    localparam int unsigned TR_W = (TILES_DOWN > 1) ? $clog2(TILES_DOWN) : 1;

    // Field widths.
    localparam int unsigned PIX_W    = 8;
    localparam int unsigned ACC_W    = 12;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned IDX_FULL_W = 13;

    localparam logic [TS_W-1:0]  TS_LAST   = TS_W'(TILE_SIZE - 1);
    localparam logic [TC_W-1:0]  TC_LAST   = TC_W'(TILES_ACROSS - 1);
    localparam logic [TR_W-1:0]  TR_LAST   = TR_W'(TILES_DOWN - 1);
    localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] THRESH_RESET = ACC_W'(625);

    // Position of the current pixel inside the tile grid (image rows count down).
    typedef struct packed {
        logic [TS_W-1:0] col_in_tile;
        logic [TC_W-1:0] tile_col;
        logic [TS_W-1:0] row_in_tile;
        logic [TR_W-1:0] tile_row;
        logic            tile_end;
        logic            frame_end;
    } t_pos;

    // One result transaction.
    typedef struct packed {
        logic             pixel_occupied;
        logic             tile_done;
        logic [IDX_W-1:0] tile_index;
        logic             tile_occupied;
        logic             frame_last;
    } t_result;

endpackage

/* sv/bto_pos.sv */
// Pixel position tracker: column and row counters split into tile and in-tile parts.
module bto_pos (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    output bto_pkg::t_pos o_pos
);

    logic [bto_pkg::TS_W-1:0] r_col_in_tile, n_col_in_tile;
    logic [bto_pkg::TC_W-1:0] r_tile_col,    n_tile_col;
    logic [bto_pkg::TS_W-1:0] r_row_in_tile, n_row_in_tile;
    logic [bto_pkg::TR_W-1:0] r_tile_row,    n_tile_row;
    logic                     col_end;
    logic                     row_end;

    assign col_end = (r_col_in_tile == bto_pkg::TS_LAST);
    assign row_end = col_end && (r_tile_col == bto_pkg::TC_LAST);

    // Next position: columns run left to right, image rows run from the bottom up.
    always_comb begin
        n_col_in_tile = r_col_in_tile;
        n_tile_col    = r_tile_col;
        n_row_in_tile = r_row_in_tile;
        n_tile_row    = r_tile_row;
        if (i_advance) begin
            if (!col_end) begin
                n_col_in_tile = r_col_in_tile + 1'b1;
            end else begin
                n_col_in_tile = '0;
                if (r_tile_col != bto_pkg::TC_LAST) begin
                    n_tile_col = r_tile_col + 1'b1;
                end else begin
                    n_tile_col = '0;
                    if (r_row_in_tile != '0) begin
                        n_row_in_tile = r_row_in_tile - 1'b1;
                    end else begin
                        n_row_in_tile = bto_pkg::TS_LAST;
                        n_tile_row    = (r_tile_row == '0) ? bto_pkg::TR_LAST
                                                           : r_tile_row - 1'b1;
                    end
                end
            end
        end
    end

    // Position registers; reset places the frame at its bottom-left pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_in_tile <= '0;
            r_tile_col    <= '0;
            r_row_in_tile <= bto_pkg::TS_LAST;
            r_tile_row    <= bto_pkg::TR_LAST;
        end else begin
            r_col_in_tile <= n_col_in_tile;
            r_tile_col    <= n_tile_col;
            r_row_in_tile <= n_row_in_tile;
            r_tile_row    <= n_tile_row;
        end
    end

    // A tile ends on its top row at its right column; the frame ends on the top-right tile.
    always_comb begin
        o_pos.col_in_tile = r_col_in_tile;
        o_pos.tile_col    = r_tile_col;
        o_pos.row_in_tile = r_row_in_tile;
        o_pos.tile_row    = r_tile_row;
        o_pos.tile_end    = col_end && (r_row_in_tile == '0);
        o_pos.frame_end   = row_end && (r_row_in_tile == '0) && (r_tile_row == '0);
    end

`ifndef SYNTHESIS
    // The frame can only end where a tile ends.
    a_frame_end_is_tile_end: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_pos.frame_end |-> o_pos.tile_end
    ) else $error("frame end without tile end");
`endif

endmodule

/* sv/bto_acc.sv */
// Pixel binarizer, per-tile-column accumulators and threshold compare.
module bto_acc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [bto_pkg::PIX_W-1:0]   i_blue,
    input  logic [bto_pkg::PIX_W-1:0]   i_green,
    input  logic [bto_pkg::PIX_W-1:0]   i_red,
    input  bto_pkg::t_pos               i_pos,
    input  logic                        i_cfg_we,
    input  logic [bto_pkg::ACC_W-1:0]   i_cfg_data,
    output bto_pkg::t_result            o_result
);

    logic [bto_pkg::ACC_W-1:0]      r_acc [bto_pkg::TILES_ACROSS];
    logic [bto_pkg::ACC_W-1:0]      r_threshold;
    logic [bto_pkg::ACC_W-1:0]      cur_count;
    logic [bto_pkg::ACC_W-1:0]      n_count;
    logic                           occ;
    logic [bto_pkg::IDX_FULL_W-1:0] idx_full;

    // A pixel is occupied only when all three bytes are zero.
    assign occ = (i_blue == '0) && (i_green == '0) && (i_red == '0);

    // Saturating count including the current pixel.
    assign cur_count = r_acc[i_pos.tile_col];
    assign n_count   = (occ && (cur_count != bto_pkg::ACC_MAX)) ? cur_count + 1'b1
                                                                : cur_count;

    // Tile index with the top tile row as zero.
    assign idx_full = bto_pkg::IDX_FULL_W'(i_pos.tile_row)
                    * bto_pkg::IDX_FULL_W'(bto_pkg::TILES_ACROSS)
                    + bto_pkg::IDX_FULL_W'(i_pos.tile_col);

    // Result fields; tile fields read zero unless a tile completes.
    always_comb begin
        o_result.pixel_occupied = occ;
        o_result.tile_done      = i_pos.tile_end;
        o_result.tile_index     = i_pos.tile_end ? idx_full[bto_pkg::IDX_W-1:0] : '0;
        o_result.tile_occupied  = i_pos.tile_end && (n_count > r_threshold);
        o_result.frame_last     = i_pos.frame_end;
    end

    // Accumulator update; a completed tile clears its column counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bto_pkg::TILES_ACROSS; k++) begin
                r_acc[k] <= '0;
            end
        end else if (i_accept) begin
            r_acc[i_pos.tile_col] <= i_pos.tile_end ? '0 : n_count;
        end
    end

    // Fill threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= bto_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

endmodule

/* sv/bto_skid.sv */
// Output register with a skid stage that holds one more result under an output stall.
module bto_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bto_pkg::t_result i_result,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output bto_pkg::t_result o_result,
    output logic             o_full
);

    logic             r_out_valid;
    logic             r_skid_valid;
    bto_pkg::t_result r_out;
    bto_pkg::t_result r_skid;
    logic             out_take;

    assign out_take = r_out_valid && !i_out_stall;

    // Control: the skid stage fills only when the output register is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_load) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (i_load) begin
            if (r_out_valid && !out_take) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign o_full      = r_skid_valid;

`ifndef SYNTHESIS
    // A buffered transaction always sits behind a valid output.
    a_skid_behind_out: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid
    ) else $error("skid stage holds data while output is empty");

    // Nothing is loaded while the skid stage is full.
    a_no_load_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_skid_valid
    ) else $error("load while skid stage is full");

    // Draining the skid stage moves its transaction to the output.
    a_skid_drains: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && out_take) |=> (r_out_valid && !r_skid_valid)
    ) else $error("skid stage failed to drain into output");
`endif

endmodule

/* sv/binarize_and_tile_occupancy.sv */
// Top level of the black-pixel binarizer with per-tile occupancy threshold.
//
//   Channel   Direction  Handshake               Payload
//   in        input      i_in_valid / o_in_stall  i_pixel_blue, i_pixel_green, i_pixel_red
//   out       output     o_out_valid / i_out_stall tile and pixel occupancy fields
//   cfg       input      i_cfg_valid / o_cfg_ready i_cfg_fill_threshold
//
// One pixel is taken per cycle while o_in_stall is low; the accumulator read,
// increment and threshold compare form its result, registered in the output register or the skid stage.
// Reset (synchronous, active low) sets the position counters to the bottom-left
// pixel, clears all tile column accumulators and loads the threshold with 625; no
// clearing pass is needed. Under an output stall one more transaction is held in a
// skid stage, after which o_in_stall rises until the output drains. The config port is always ready.
module binarize_and_tile_occupancy (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [bto_pkg::PIX_W-1:0] i_pixel_blue,
    input  logic [bto_pkg::PIX_W-1:0] i_pixel_green,
    input  logic [bto_pkg::PIX_W-1:0] i_pixel_red,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_pixel_occupied,
    output logic                      o_tile_done,
    output logic [bto_pkg::IDX_W-1:0] o_tile_index,
    output logic                      o_tile_occupied,
    output logic                      o_frame_last,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bto_pkg::ACC_W-1:0] i_cfg_fill_threshold
);

    logic             accept;
    logic             full;
    bto_pkg::t_pos    pos;
    bto_pkg::t_result result;
    bto_pkg::t_result out_result;

    assign accept      = i_in_valid && !full;
    assign o_in_stall  = full;
    assign o_cfg_ready = 1'b1;

    // Pixel position within the frame.
    bto_pos u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .o_pos     (pos)
    );

    // Binarize, accumulate and compare.
    bto_acc u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_blue     (i_pixel_blue),
        .i_green    (i_pixel_green),
        .i_red      (i_pixel_red),
        .i_pos      (pos),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_fill_threshold),
        .o_result   (result)
    );

    // Output register and skid stage.
    bto_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (out_result),
        .o_full      (full)
    );

    assign o_pixel_occupied = out_result.pixel_occupied;
    assign o_tile_done      = out_result.tile_done;
    assign o_tile_index     = out_result.tile_index;
    assign o_tile_occupied  = out_result.tile_occupied;
    assign o_frame_last     = out_result.frame_last;

endmodule

/* tb/tb_binarize_and_tile_occupancy.sv */
// Self-checking testbench for the black-pixel binarizer and tile occupancy block.
module tb_binarize_and_tile_occupancy;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD   = 12;
    localparam int unsigned FRAME_W      = bto_pkg::TILES_ACROSS * bto_pkg::TILE_SIZE;
    localparam int unsigned FRAME_H      = bto_pkg::TILES_DOWN * bto_pkg::TILE_SIZE;
    localparam int unsigned TILE_AREA    = bto_pkg::TILE_SIZE * bto_pkg::TILE_SIZE;
    // Coprime with the tile area, so stepping by it visits every tile position once.
    localparam int unsigned SCATTER_STEP = 37;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned HOLD_LEN     = 400;
    localparam int unsigned HOLD_AT_A    = 300;
    localparam int unsigned HOLD_AT_B    = 1000;
    localparam int          NUM_PHASES   = 6;

    typedef struct packed {
        logic [bto_pkg::PIX_W-1:0] blue;
        logic [bto_pkg::PIX_W-1:0] green;
        logic [bto_pkg::PIX_W-1:0] red;
    } t_pixel;

    // Block ports.
    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic [bto_pkg::PIX_W-1:0] pix_blue      = '0;
    logic [bto_pkg::PIX_W-1:0] pix_green     = '0;
    logic [bto_pkg::PIX_W-1:0] pix_red       = '0;
    logic                      out_valid;
    logic                      out_stall     = 1'b0;
    logic                      res_pixel_occupied;
    logic                      res_tile_done;
    logic [bto_pkg::IDX_W-1:0] res_tile_index;
    logic                      res_tile_occupied;
    logic                      res_frame_last;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [bto_pkg::ACC_W-1:0] cfg_threshold = '0;

    // Stimulus and expectation stores.
    t_pixel           pixel_stream[$];
    bto_pkg::t_result expected_results[$];

    // Predictor state.
    int unsigned               model_col;
    int unsigned               model_row;
    logic [bto_pkg::ACC_W-1:0] model_count [bto_pkg::TILES_ACROSS];
    logic [bto_pkg::ACC_W-1:0] model_thr;

    // Run control and statistics.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left     = 0;
    int unsigned idle_cycles   = 0;
    int unsigned error_count   = 0;
    int unsigned pixels_sent   = 0;
    int unsigned results_seen  = 0;
    int unsigned tiles_seen    = 0;
    int unsigned tiles_marked  = 0;
    int unsigned frames_seen   = 0;
    int unsigned cfg_writes    = 0;
    int unsigned phase_items [NUM_PHASES] = '{225, 225, 225, 225, 225, 225};
    int unsigned phase_thr   [NUM_PHASES] = '{625, 0, 2500, 0, 1, 2499};

    binarize_and_tile_occupancy dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_pixel_blue         (pix_blue),
        .i_pixel_green        (pix_green),
        .i_pixel_red          (pix_red),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_pixel_occupied     (res_pixel_occupied),
        .o_tile_done          (res_tile_done),
        .o_tile_index         (res_tile_index),
        .o_tile_occupied      (res_tile_occupied),
        .o_frame_last         (res_frame_last),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_fill_threshold (cfg_threshold)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Works out the result of one pixel and advances the frame position.
    task automatic predict_occupancy(input t_pixel px, output bto_pkg::t_result res);
        int unsigned img_row;
        int unsigned tcol;
        int unsigned trow;
        logic        occ;
        occ = (10'(px.blue) + 10'(px.green) + 10'(px.red)) == 10'd0;
        img_row = FRAME_H - 1 - model_row;
        tcol = model_col / bto_pkg::TILE_SIZE;
        if (tcol >= bto_pkg::TILES_ACROSS) tcol = bto_pkg::TILES_ACROSS - 1;
        trow = img_row / bto_pkg::TILE_SIZE;
        if (occ && model_count[tcol] != bto_pkg::ACC_MAX)
            model_count[tcol] = model_count[tcol] + 1'b1;

        res = '0;
        res.pixel_occupied = occ;
        res.tile_done = (img_row % bto_pkg::TILE_SIZE == 0) &&
                        (model_col % bto_pkg::TILE_SIZE == bto_pkg::TILE_SIZE - 1);
        res.frame_last = (model_row == FRAME_H - 1) && (model_col == FRAME_W - 1);
        if (res.tile_done) begin
            res.tile_index = bto_pkg::IDX_W'(trow * bto_pkg::TILES_ACROSS + tcol);
            res.tile_occupied = model_count[tcol] > model_thr;
            model_count[tcol] = '0;
        end

        // Walk the raster; the frame wraps after its last pixel.
        if (model_col + 1 >= FRAME_W) begin
            model_col = 0;
            model_row = (model_row + 1 >= FRAME_H) ? 0 : model_row + 1;
        end else begin
            model_col = model_col + 1;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Returns once every queued pixel has gone in and every result has come out.
    task automatic wait_until_drained();
        while (pixel_stream.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Input driver: offers queued pixels and predicts each accepted transaction.
    always @(posedge clk) begin : drive_pixels
        bto_pkg::t_result res;
        t_pixel           px;
        logic             take;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take = in_valid && !in_stall;
            if (take) begin
                predict_occupancy({pix_blue, pix_green, pix_red}, res);
                expected_results.insert(expected_results.size(), res);
                pixels_sent++;
            end
            // A stalled transaction keeps its payload until it is taken.
            if (!in_valid || take) begin
                if (pixel_stream.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    px = pixel_stream.pop_front();
                    pix_blue  <= px.blue;
                    pix_green <= px.green;
                    pix_red   <= px.red;
                    in_valid  <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted transaction with the oldest prediction.
    always @(posedge clk) begin : check_results
        bto_pkg::t_result want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result with no pending prediction, expected none, actual %b",
                             $time, {res_pixel_occupied, res_tile_done, res_tile_index,
                                     res_tile_occupied, res_frame_last});
                end else begin
                    want = expected_results.pop_front();
                    check_field("pixel_occupied", 8'(want.pixel_occupied),
                                8'(res_pixel_occupied));
                    check_field("tile_done", 8'(want.tile_done), 8'(res_tile_done));
                    check_field("tile_index", 8'(want.tile_index), 8'(res_tile_index));
                    check_field("tile_occupied", 8'(want.tile_occupied), 8'(res_tile_occupied));
                    check_field("frame_last", 8'(want.frame_last), 8'(res_frame_last));
                    if (want.tile_done) tiles_seen++;
                    if (want.tile_occupied) tiles_marked++;
                    if (want.frame_last) frames_seen++;
                end
                // Long hold-offs let the block fill up and stall its input.
                if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) hold_left = HOLD_LEN;
            end
            if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Stimulus: directed corner pixels, then pixels with planned black counts per tile.
    initial begin : run_test
        t_pixel      directed[$];
        t_pixel      px;
        logic [7:0]  v;
        int unsigned gen_col;
        int unsigned gen_row;
        int unsigned band_target [bto_pkg::TILES_ACROSS];
        int unsigned band_spread [bto_pkg::TILES_ACROSS];
        logic        band_noisy  [bto_pkg::TILES_ACROSS];
        int unsigned t;
        int unsigned p;
        int          thr;
        int          k;

        directed = '{24'h000000, 24'hFFFFFF, 24'h010000, 24'h000100,
                     24'h000001, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                     24'h800000, 24'h008000, 24'h000080, 24'h000000,
                     24'h55AA55, 24'hAA55AA, 24'h010101, 24'hFFFF00,
                     24'h00FFFF, 24'hFF00FF, 24'h7F7F7F, 24'h000000};
        model_thr = bto_pkg::THRESH_RESET;
        model_col = 0;
        model_row = 0;
        foreach (model_count[i]) model_count[i] = '0;
        gen_col = 0;
        gen_row = 0;
        phase_thr[3] = $urandom_range(TILE_AREA - 1, 1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // The first phase runs on the threshold loaded by reset.
            if (ph != 0) begin
                wait_until_drained();
                repeat (4) @(posedge clk);
                cfg_valid     <= 1'b1;
                cfg_threshold <= bto_pkg::ACC_W'(phase_thr[ph]);
                do @(posedge clk); while (!cfg_ready);
                model_thr = bto_pkg::ACC_W'(phase_thr[ph]);
                cfg_valid <= 1'b0;
                cfg_writes++;
            end
            send_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 58 : 0;
            recv_idle_pct = (ph < 2) ? 58 : (ph < 4) ? 29 : 0;
            thr = phase_thr[ph];

            for (int n = 0; n < phase_items[ph]; n++) begin
                // Per band, each tile's black count: near threshold, none, all or random.
                if (gen_row % bto_pkg::TILE_SIZE == 0 && gen_col == 0) begin
                    for (int c = 0; c < bto_pkg::TILES_ACROSS; c++) begin
                        case ($urandom_range(6, 0))
                            0: k = thr;
                            1: k = thr + 1;
                            2: k = thr - 1;
                            3: k = 0;
                            4: k = TILE_AREA;
                            default: k = $urandom_range(TILE_AREA, 0);
                        endcase
                        if (k < 0) k = 0;
                        if (k > TILE_AREA) k = TILE_AREA;
                        band_target[c] = k;
                        band_spread[c] = $urandom_range(TILE_AREA - 1, 0);
                        band_noisy[c]  = ($urandom_range(3, 0) == 0);
                    end
                end
                t = gen_col / bto_pkg::TILE_SIZE;
                p = (gen_row % bto_pkg::TILE_SIZE) * bto_pkg::TILE_SIZE
                  + gen_col % bto_pkg::TILE_SIZE;

                if (directed.size() != 0) begin
                    px = directed.pop_front();
                end else if ((p * SCATTER_STEP + band_spread[t]) % TILE_AREA < band_target[t]) begin
                    px = '0;
                end else begin
                    // Free pixel: random bytes, or a single nonzero byte.
                    px = 24'($urandom);
                    if ($urandom_range(3, 0) == 0) begin
                        v = 8'($urandom_range(255, 1));
                        case ($urandom_range(2, 0))
                            0: px = {v, 8'h00, 8'h00};
                            1: px = {8'h00, v, 8'h00};
                            default: px = {8'h00, 8'h00, v};
                        endcase
                    end
                    if (px == '0) px.red = 8'($urandom_range(255, 1));
                end
                // Noisy tiles get stray pixels that break the planned count.
                if (band_noisy[t] && $urandom_range(63, 0) == 0)
                    px = ($urandom_range(1, 0) != 0) ? t_pixel'('0) : t_pixel'(24'($urandom));
                pixel_stream.insert(pixel_stream.size(), px);

                if (gen_col + 1 >= FRAME_W) begin
                    gen_col = 0;
                    gen_row = (gen_row + 1 >= FRAME_H) ? 0 : gen_row + 1;
                end else begin
                    gen_col = gen_col + 1;
                end
            end
        end

        wait_until_drained();
        repeat (10) @(posedge clk);

        $display("Covered %0d pixels, %0d frame ends and %0d tiles, %0d of them above threshold.",
                 pixels_sent, frames_seen, tiles_seen, tiles_marked);
        $display("Threshold written %0d times under random gaps and long hold-offs; %0d errors.",
                 cfg_writes, error_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
